@@ hdl/swrphm_pkg.sv @@
`timescale 1ns / 1ps

package swrphm_pkg;

    // Field and state widths
    localparam int SWR_W    = 14;
    localparam int FRAC_W   = 16;
    localparam int CNT_W    = 16;
    localparam int RUN_W    = 4;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CLS_W    = 2;
    localparam int EXP_W    = 4;
    localparam int ROM_W    = 17;
    localparam int DIFF_W   = 13;
    localparam int LOG_W    = 20;
    localparam int MUL_A_W  = 20;
    localparam int MUL_B_W  = 16;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;

    // Scale constants
    localparam int SWR_UNITY    = 100;
    localparam int SWR_REAL_MIN = 101;
    localparam int DECAY_EPS    = 66;
    localparam int FRAC_FULL    = 65535;
    localparam int RUN_SAT      = 15;
    localparam int UNITY_RUN_NEEDED = 10;
    localparam int LOG_TABLE_BITS_DEF = 8;

    // Register reset values
    localparam int SWR_MAX_RST         = 1000;
    localparam int INVERSE_LOG_MAX_RST = 19728;
    localparam int DECAY_RATE_RST      = 9830;
    localparam int PEAK_DECAY_RATE_RST = 3277;
    localparam int HOLD_TICKS_RST      = 25;
    localparam int GOOD_LIMIT_RST      = 150;
    localparam int WARNING_LIMIT_RST   = 300;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SWR_MAX         = 3'd0,
        REG_INVERSE_LOG_MAX = 3'd1,
        REG_DECAY_RATE      = 3'd2,
        REG_PEAK_DECAY_RATE = 3'd3,
        REG_HOLD_TICKS      = 3'd4,
        REG_GOOD_LIMIT      = 3'd5,
        REG_WARNING_LIMIT   = 3'd6,
        REG_TUNE_MODE       = 3'd7
    } cfg_idx_t;

    typedef enum logic [CLS_W-1:0] {
        CLS_BLANK   = 2'd0,
        CLS_GOOD    = 2'd1,
        CLS_WARNING = 2'd2,
        CLS_BAD     = 2'd3
    } color_class_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_LOG,
        ST_INTERP,
        ST_SCALE,
        ST_UPD,
        ST_PEAK,
        ST_FIN
    } ctrl_state_t;

    typedef struct packed {
        logic load_in;
        logic do_eval;
        logic do_log;
        logic do_interp;
        logic do_scale;
        logic do_upd;
        logic do_peak;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic need_frac;
        logic is_tick;
        logic out_free;
    } dp_sts_t;

    // log2 of x in [1,2) given in Q2.30, rounded to Q0.16 (elaboration only)
    function automatic int mant_log2(logic [63:0] x);
        logic [63:0] y;
        logic [17:0] r;
        y = x;
        r = '0;
        for (int k = 0; k < 17; k++) begin
            y = (y * y) >> 30;
            r = {r[16:0], 1'b0};
            if (y >= 64'h8000_0000) begin
                y = y >> 1;
                r[0] = 1'b1;
            end
        end
        return int'((r + 18'd1) >> 1);
    endfunction

    function automatic int log_rom_entry(int idx, int bits);
        if (idx == (1 << bits)) begin
            return 65536;
        end
        return mant_log2((64'd1 << 30) + (64'(idx) << (30 - bits)));
    endfunction

    // log2 in Q.16 of a constant, with the same table interpolation as the hardware
    function automatic int log2_q16_const(int s, int bits);
        int e, m, f, idx, rem, a, b, sub;
        sub = 13 - bits;
        e = 0;
        for (int k = 0; k < 13; k++) begin
            if ((s >> (k + 1)) != 0) begin
                e = k + 1;
            end
        end
        m = (s << (13 - e)) & 16'h3FFF;
        f = m - 8192;
        idx = f >> sub;
        rem = f & ((1 << sub) - 1);
        a = log_rom_entry(idx, bits);
        b = log_rom_entry(idx + 1, bits);
        return (e << 16) + a + (((b - a) * rem + (1 << (sub - 1))) >> sub);
    endfunction

endpackage

@@ hdl/swr_peak_hold_meter_top.sv @@
`timescale 1ns / 1ps

// SWR peak-hold meter. Each input beat is either an SWR sample (mode 0, in
// hundredths) or a decay tick (mode 1), and every beat yields exactly one
// result beat: the Q0.16 bar and peak levels on a log scale, the number to
// show, whether to show it and a colour class. A sample taken with power
// present and accepted by the unity filter runs evaluate, look-up,
// interpolate, scale, update and output before the block is ready again; a
// tick adds a peak step; a sample without power or one that the unity filter
// holds back goes from evaluate to output. One 20x16 multiplier in turn does the table interpolation of
// log2, the scaling by inverse_log_max, the bar decay and the peak decay.
// The result sits in an output register, so a new beat is taken while the
// last result still waits; a further result waits for that register to
// drain. Configuration writes on cfg_we/cfg_addr/cfg_data take effect at
// once and belong only in idle periods. The log2 table has
// 2^LOG_TABLE_BITS+1 entries and is built as constants at elaboration.
module swr_peak_hold_meter_top #(
    parameter int LOG_TABLE_BITS = swrphm_pkg::LOG_TABLE_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // input channel
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  mode,
    input  logic [swrphm_pkg::SWR_W-1:0]          swr_sample,
    input  logic                                  power_present,
    // configuration writes
    input  logic                                  cfg_we,
    input  logic [swrphm_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [swrphm_pkg::CFG_W-1:0]          cfg_data,
    // result channel
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [swrphm_pkg::FRAC_W-1:0]         bar_fraction,
    output logic [swrphm_pkg::FRAC_W-1:0]         peak_fraction,
    output logic [swrphm_pkg::SWR_W-1:0]          shown_swr,
    output logic                                  show_value,
    output logic [swrphm_pkg::CLS_W-1:0]          color_class
);
    import swrphm_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // Sequence the steps: evaluate, look up, interpolate, scale, update, peak, output
    swrphm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Hold the meter state, configuration and the shared multiplier
    swrphm_dp #(
        .LOG_TABLE_BITS (LOG_TABLE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .mode          (mode),
        .swr_sample    (swr_sample),
        .power_present (power_present),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .bar_fraction  (bar_fraction),
        .peak_fraction (peak_fraction),
        .shown_swr     (shown_swr),
        .show_value    (show_value),
        .color_class   (color_class)
    );

endmodule

@@ hdl/swrphm_ctrl.sv @@
`timescale 1ns / 1ps

module swrphm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  swrphm_pkg::dp_sts_t sts,
    output swrphm_pkg::dp_cmd_t cmd
);
    import swrphm_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:   state_next = sts.need_frac ? ST_LOG : ST_FIN;
            ST_LOG:    state_next = ST_INTERP;
            ST_INTERP: state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_UPD;
            ST_UPD:    state_next = sts.is_tick ? ST_PEAK : ST_FIN;
            ST_PEAK:   state_next = ST_FIN;
            ST_FIN:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            ST_EVAL:   cmd.do_eval   = 1'b1;
            ST_LOG:    cmd.do_log    = 1'b1;
            ST_INTERP: cmd.do_interp = 1'b1;
            ST_SCALE:  cmd.do_scale  = 1'b1;
            ST_UPD:    cmd.do_upd    = 1'b1;
            ST_PEAK:   cmd.do_peak   = 1'b1;
            ST_FIN:    cmd.load_out  = sts.out_free;
            default:   cmd = '0;
        endcase
    end

endmodule

@@ hdl/swrphm_dp.sv @@
`timescale 1ns / 1ps

module swrphm_dp #(
    parameter int LOG_TABLE_BITS = swrphm_pkg::LOG_TABLE_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  swrphm_pkg::dp_cmd_t                   cmd,
    output swrphm_pkg::dp_sts_t                   sts,
    input  logic                                  mode,
    input  logic [swrphm_pkg::SWR_W-1:0]          swr_sample,
    input  logic                                  power_present,
    input  logic                                  cfg_we,
    input  logic [swrphm_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [swrphm_pkg::CFG_W-1:0]          cfg_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [swrphm_pkg::FRAC_W-1:0]         bar_fraction,
    output logic [swrphm_pkg::FRAC_W-1:0]         peak_fraction,
    output logic [swrphm_pkg::SWR_W-1:0]          shown_swr,
    output logic                                  show_value,
    output logic [swrphm_pkg::CLS_W-1:0]          color_class
);
    import swrphm_pkg::*;

    localparam int SubBits = 13 - LOG_TABLE_BITS;
    localparam int RomSize = (1 << LOG_TABLE_BITS) + 1;
    localparam int Log100  = log2_q16_const(SWR_UNITY, LOG_TABLE_BITS);

    // Log table
    logic [ROM_W-1:0] log_rom [RomSize];

    for (genvar g = 0; g < RomSize; g++)
    begin : g_rom
        localparam logic [ROM_W-1:0] RomVal = ROM_W'(log_rom_entry(g, LOG_TABLE_BITS));
        assign log_rom[g] = RomVal;
    end

    // Configuration
    logic [SWR_W-1:0]  swr_max_reg;
    logic [CFG_W-1:0]  inverse_log_max_reg;
    logic [CFG_W-1:0]  decay_rate_reg;
    logic [CFG_W-1:0]  peak_decay_rate_reg;
    logic [CNT_W-1:0]  hold_ticks_reg;
    logic [SWR_W-1:0]  good_limit_reg;
    logic [SWR_W-1:0]  warning_limit_reg;
    logic              tune_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            swr_max_reg         <= SWR_W'(SWR_MAX_RST);
            inverse_log_max_reg <= CFG_W'(INVERSE_LOG_MAX_RST);
            decay_rate_reg      <= CFG_W'(DECAY_RATE_RST);
            peak_decay_rate_reg <= CFG_W'(PEAK_DECAY_RATE_RST);
            hold_ticks_reg      <= CNT_W'(HOLD_TICKS_RST);
            good_limit_reg      <= SWR_W'(GOOD_LIMIT_RST);
            warning_limit_reg   <= SWR_W'(WARNING_LIMIT_RST);
            tune_mode_reg       <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_addr))
                REG_SWR_MAX:         swr_max_reg         <= cfg_data[SWR_W-1:0];
                REG_INVERSE_LOG_MAX: inverse_log_max_reg <= cfg_data;
                REG_DECAY_RATE:      decay_rate_reg      <= cfg_data;
                REG_PEAK_DECAY_RATE: peak_decay_rate_reg <= cfg_data;
                REG_HOLD_TICKS:      hold_ticks_reg      <= cfg_data[CNT_W-1:0];
                REG_GOOD_LIMIT:      good_limit_reg      <= cfg_data[SWR_W-1:0];
                REG_WARNING_LIMIT:   warning_limit_reg   <= cfg_data[SWR_W-1:0];
                REG_TUNE_MODE:       tune_mode_reg       <= cfg_data[0];
                default:             tune_mode_reg       <= tune_mode_reg;
            endcase
        end
    end

    // Latched beat and meter state
    logic                      mode_reg, mode_next;
    logic [SWR_W-1:0]          samp_reg, samp_next;
    logic                      pwr_reg, pwr_next;
    logic [SWR_W-1:0]          current_swr_reg, current_swr_next;
    logic [SWR_W-1:0]          last_active_swr_reg, last_active_swr_next;
    logic [CNT_W-1:0]          numeric_hold_count_reg, numeric_hold_count_next;
    logic [RUN_W-1:0]          unity_run_count_reg, unity_run_count_next;
    logic [FRAC_W-1:0]         bar_level_reg, bar_level_next;
    logic [FRAC_W-1:0]         peak_level_reg, peak_level_next;
    logic [CNT_W-1:0]          peak_hold_count_reg, peak_hold_count_next;

    // Fraction datapath
    logic [SWR_W-1:0]          fs_reg, fs_next;
    logic [EXP_W-1:0]          e_reg, e_next;
    logic [ROM_W-1:0]          a_reg, a_next;
    logic [DIFF_W-1:0]         d_reg, d_next;
    logic [SubBits-1:0]        rem_reg, rem_next;
    logic [LOG_W-1:0]          logd_reg, logd_next;
    logic [FRAC_W-1:0]         frac_reg, frac_next;

    // Result register
    logic                      out_valid_reg, out_valid_next;
    logic [FRAC_W-1:0]         bar_out_reg;
    logic [FRAC_W-1:0]         peak_out_reg;
    logic [SWR_W-1:0]          shown_out_reg;
    logic                      show_out_reg;
    logic [CLS_W-1:0]          cls_out_reg;

    // Sample decision
    logic                      is_unity;
    logic                      hold_real;
    logic [RUN_W-1:0]          unity_inc;
    logic                      accept_s;
    logic [SWR_W-1:0]          clamp_hi;
    logic [SWR_W-1:0]          clamp_v;

    assign is_unity  = samp_reg <= SWR_W'(SWR_UNITY);
    assign hold_real = (last_active_swr_reg > SWR_W'(SWR_REAL_MIN))
                       && (numeric_hold_count_reg != '0);
    assign unity_inc = (unity_run_count_reg == RUN_W'(RUN_SAT))
                       ? unity_run_count_reg : unity_run_count_reg + RUN_W'(1);
    assign accept_s  = !mode_reg && pwr_reg
                       && (!is_unity
                           || (!hold_real && (unity_inc >= RUN_W'(UNITY_RUN_NEEDED))));
    assign clamp_hi  = (samp_reg > swr_max_reg) ? swr_max_reg : samp_reg;
    assign clamp_v   = (clamp_hi < SWR_W'(SWR_UNITY)) ? SWR_W'(SWR_UNITY) : clamp_hi;

    assign sts.need_frac = mode_reg || accept_s;
    assign sts.is_tick   = mode_reg;
    assign sts.out_free  = !out_valid_reg || out_ready;

    // Normalise and look up the table
    logic [EXP_W-1:0]          lead;
    logic [SWR_W-1:0]          norm;
    logic [LOG_TABLE_BITS-1:0] idx_lo;
    logic [LOG_TABLE_BITS:0]   idx_hi;
    logic [ROM_W-1:0]          rom_lo;
    logic [ROM_W-1:0]          rom_hi;

    always_comb
    begin
        lead = '0;
        for (int k = 1; k < SWR_W; k++)
        begin
            if (fs_reg[k])
            begin
                lead = EXP_W'(k);
            end
        end
    end

    assign norm   = fs_reg << (EXP_W'(SWR_W - 1) - lead);
    assign idx_lo = norm[12:SubBits];
    assign idx_hi = {1'b0, idx_lo} + {{LOG_TABLE_BITS{1'b0}}, 1'b1};
    assign rom_lo = log_rom[{1'b0, idx_lo}];
    assign rom_hi = log_rom[idx_hi];

    // Shared multiplier
    logic [MUL_A_W-1:0]        mul_a;
    logic [MUL_B_W-1:0]        mul_b;
    logic [PROD_W-1:0]         prod;
    logic [FRAC_W-1:0]         bar_gap;
    logic [FRAC_W-1:0]         peak_gap;
    logic                      bar_dec_on;
    logic                      peak_dec_on;

    assign bar_gap     = bar_level_reg - frac_reg;
    assign peak_gap    = peak_level_reg - bar_level_reg;
    assign bar_dec_on  = {1'b0, bar_level_reg} > ({1'b0, frac_reg} + (FRAC_W+1)'(DECAY_EPS));
    assign peak_dec_on = {1'b0, peak_level_reg}
                         > ({1'b0, bar_level_reg} + (FRAC_W+1)'(DECAY_EPS));

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.do_interp)
        begin
            mul_a = MUL_A_W'(d_reg);
            mul_b = MUL_B_W'(rem_reg);
        end
        else if (cmd.do_scale)
        begin
            mul_a = logd_reg;
            mul_b = inverse_log_max_reg;
        end
        else if (cmd.do_upd)
        begin
            mul_a = MUL_A_W'(bar_gap);
            mul_b = decay_rate_reg;
        end
        else if (cmd.do_peak)
        begin
            mul_a = MUL_A_W'(peak_gap);
            mul_b = peak_decay_rate_reg;
        end
    end

    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Results of each step
    logic [PROD_W-1:0]         interp_w;
    logic [LOG_W:0]            log_sum;
    logic [PROD_W-1:0]         scaled;
    logic [LOG_W-1:0]          rnd;
    logic [FRAC_W-1:0]         frac_sat;
    logic [FRAC_W-1:0]         bar_step;
    logic [FRAC_W-1:0]         peak_step;

    assign interp_w = (prod + PROD_W'(1 << (SubBits - 1))) >> SubBits;
    assign log_sum  = (LOG_W+1)'({e_reg, 16'b0}) + (LOG_W+1)'(a_reg)
                      + (LOG_W+1)'(interp_w[DIFF_W:0]);
    assign scaled   = prod + PROD_W'(32768);
    assign rnd      = scaled[PROD_W-1:16];
    assign frac_sat = (rnd > LOG_W'(FRAC_FULL)) ? FRAC_W'(FRAC_FULL) : rnd[FRAC_W-1:0];
    assign bar_step  = bar_level_reg - prod[31:16];
    assign peak_step = peak_level_reg - prod[31:16];

    // Next state of the meter
    always_comb
    begin
        mode_next               = mode_reg;
        samp_next               = samp_reg;
        pwr_next                = pwr_reg;
        current_swr_next        = current_swr_reg;
        last_active_swr_next    = last_active_swr_reg;
        numeric_hold_count_next = numeric_hold_count_reg;
        unity_run_count_next    = unity_run_count_reg;
        bar_level_next          = bar_level_reg;
        peak_level_next         = peak_level_reg;
        peak_hold_count_next    = peak_hold_count_reg;
        fs_next                 = fs_reg;
        e_next                  = e_reg;
        a_next                  = a_reg;
        d_next                  = d_reg;
        rem_next                = rem_reg;
        logd_next               = logd_reg;
        frac_next               = frac_reg;

        if (cmd.load_in)
        begin
            mode_next = mode;
            samp_next = swr_sample;
            pwr_next  = power_present;
        end

        if (cmd.do_eval)
        begin
            if (!mode_reg && pwr_reg)
            begin
                if (!is_unity)
                begin
                    unity_run_count_next = '0;
                end
                else if (!hold_real)
                begin
                    unity_run_count_next = unity_inc;
                end
            end
            if (accept_s)
            begin
                current_swr_next        = clamp_v;
                last_active_swr_next    = clamp_v;
                numeric_hold_count_next = hold_ticks_reg;
                fs_next                 = clamp_v;
            end
            if (mode_reg)
            begin
                fs_next = current_swr_reg;
                if ((numeric_hold_count_reg != '0) && !pwr_reg && !tune_mode_reg)
                begin
                    numeric_hold_count_next = numeric_hold_count_reg - CNT_W'(1);
                end
            end
        end

        if (cmd.do_log)
        begin
            e_next   = lead;
            a_next   = rom_lo;
            d_next   = DIFF_W'(rom_hi - rom_lo);
            rem_next = norm[SubBits-1:0];
        end

        if (cmd.do_interp)
        begin
            logd_next = LOG_W'(log_sum - (LOG_W+1)'(Log100));
        end

        if (cmd.do_scale)
        begin
            if (fs_reg <= SWR_W'(SWR_UNITY))
            begin
                frac_next = '0;
            end
            else if (fs_reg >= swr_max_reg)
            begin
                frac_next = FRAC_W'(FRAC_FULL);
            end
            else
            begin
                frac_next = frac_sat;
            end
        end

        if (cmd.do_upd)
        begin
            if (mode_reg)
            begin
                // decay the bar towards the current reading
                if (bar_dec_on)
                begin
                    bar_level_next = (bar_step < frac_reg) ? frac_reg : bar_step;
                end
            end
            else
            begin
                if (frac_reg > bar_level_reg)
                begin
                    bar_level_next = frac_reg;
                end
                if (frac_reg > peak_level_reg)
                begin
                    peak_level_next      = frac_reg;
                    peak_hold_count_next = hold_ticks_reg;
                end
            end
        end

        if (cmd.do_peak && peak_dec_on)
        begin
            if (peak_hold_count_reg != '0)
            begin
                peak_hold_count_next = peak_hold_count_reg - CNT_W'(1);
            end
            else
            begin
                peak_level_next = (peak_step < bar_level_reg) ? bar_level_reg : peak_step;
            end
        end
    end

    // Result formatting
    logic              show_w;
    logic [SWR_W-1:0]  shown_w;
    color_class_t      cls_w;

    always_comb
    begin
        show_w  = 1'b0;
        shown_w = '0;
        cls_w   = CLS_BLANK;
        if (pwr_reg)
        begin
            show_w  = 1'b1;
            shown_w = current_swr_reg;
        end
        else if ((tune_mode_reg || (numeric_hold_count_reg != '0))
                 && (last_active_swr_reg > SWR_W'(SWR_UNITY)))
        begin
            show_w  = 1'b1;
            shown_w = last_active_swr_reg;
        end
        if (show_w)
        begin
            if (shown_w < good_limit_reg)
            begin
                cls_w = CLS_GOOD;
            end
            else if (shown_w < warning_limit_reg)
            begin
                cls_w = CLS_WARNING;
            end
            else
            begin
                cls_w = CLS_BAD;
            end
        end
    end

    assign out_valid_next = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    // Control and meter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_swr_reg        <= SWR_W'(SWR_UNITY);
            last_active_swr_reg    <= SWR_W'(SWR_UNITY);
            numeric_hold_count_reg <= '0;
            unity_run_count_reg    <= '0;
            bar_level_reg          <= '0;
            peak_level_reg         <= '0;
            peak_hold_count_reg    <= '0;
            out_valid_reg          <= 1'b0;
        end
        else
        begin
            current_swr_reg        <= current_swr_next;
            last_active_swr_reg    <= last_active_swr_next;
            numeric_hold_count_reg <= numeric_hold_count_next;
            unity_run_count_reg    <= unity_run_count_next;
            bar_level_reg          <= bar_level_next;
            peak_level_reg         <= peak_level_next;
            peak_hold_count_reg    <= peak_hold_count_next;
            out_valid_reg          <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        samp_reg <= samp_next;
        pwr_reg  <= pwr_next;
        fs_reg   <= fs_next;
        e_reg    <= e_next;
        a_reg    <= a_next;
        d_reg    <= d_next;
        rem_reg  <= rem_next;
        logd_reg <= logd_next;
        frac_reg <= frac_next;
        if (cmd.load_out)
        begin
            bar_out_reg   <= bar_level_reg;
            peak_out_reg  <= peak_level_reg;
            shown_out_reg <= shown_w;
            show_out_reg  <= show_w;
            cls_out_reg   <= cls_w;
        end
    end

    assign out_valid     = out_valid_reg;
    assign bar_fraction  = bar_out_reg;
    assign peak_fraction = peak_out_reg;
    assign shown_swr     = shown_out_reg;
    assign show_value    = show_out_reg;
    assign color_class   = cls_out_reg;

`ifndef SYNTHESIS
    a_peak_not_below_bar: assert property (@(posedge clk) disable iff (!rst_n)
        peak_level_reg >= bar_level_reg)
        else $error("peak marker fell below the bar");

    a_current_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        current_swr_reg >= SWR_W'(SWR_UNITY))
        else $error("held SWR below unity");

    a_unity_run_only_on_eval: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.do_eval |=> $stable(unity_run_count_reg))
        else $error("unity run count moved outside evaluation");

    a_reject_keeps_bar: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.do_eval && !sts.need_frac) |=> ##1 $stable(bar_level_reg))
        else $error("rejected sample changed the bar");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten before it was taken");
`endif

endmodule

@@ dv/swr_peak_hold_meter_top_test.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the SWR peak-hold meter. Beats go in on a
// valid/ready channel with random gaps, the result channel is stalled at
// random, and every result beat is checked field by field against a
// bench-side model of the meter ballistics. The run moves through several
// register settings, the extremes among them.
module swr_peak_hold_meter_top_test;

    import swrphm_pkg::*;

    localparam int LOG_BITS        = LOG_TABLE_BITS_DEF;
    localparam int SUB_BITS        = 13 - LOG_BITS;
    localparam int TAB_LEN         = (1 << LOG_BITS) + 1;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 12;
    localparam int CYCLE_LIMIT     = 200000;

    // One expected result beat
    typedef struct {
        logic [FRAC_W-1:0] bar;
        logic [FRAC_W-1:0] peak;
        logic [SWR_W-1:0]  shown;
        logic              show;
        color_class_t      cls;
    } meter_reading_t;

    // Block ports; every input holds a known value from time zero
    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 in_valid      = 1'b0;
    logic                 in_ready;
    logic                 mode          = 1'b0;
    logic [SWR_W-1:0]     swr_sample    = '0;
    logic                 power_present = 1'b0;
    logic                 cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr      = '0;
    logic [CFG_W-1:0]     cfg_data      = '0;
    logic                 out_valid;
    logic                 out_ready     = 1'b0;
    logic [FRAC_W-1:0]    bar_fraction;
    logic [FRAC_W-1:0]    peak_fraction;
    logic [SWR_W-1:0]     shown_swr;
    logic                 show_value;
    logic [CLS_W-1:0]     color_class;

    // Bench copy of the registers, at their reset values
    logic [SWR_W-1:0]  scale_max     = SWR_W'(SWR_MAX_RST);
    logic [CFG_W-1:0]  inv_log_scale = CFG_W'(INVERSE_LOG_MAX_RST);
    logic [CFG_W-1:0]  bar_decay     = CFG_W'(DECAY_RATE_RST);
    logic [CFG_W-1:0]  peak_decay    = CFG_W'(PEAK_DECAY_RATE_RST);
    logic [CNT_W-1:0]  hold_len      = CNT_W'(HOLD_TICKS_RST);
    logic [SWR_W-1:0]  good_lim      = SWR_W'(GOOD_LIMIT_RST);
    logic [SWR_W-1:0]  warn_lim      = SWR_W'(WARNING_LIMIT_RST);
    logic              tune_on       = 1'b0;

    // Bench copy of the meter state
    logic [SWR_W-1:0]  held_swr    = SWR_W'(SWR_UNITY);
    logic [SWR_W-1:0]  last_tx_swr = SWR_W'(SWR_UNITY);
    logic [CNT_W-1:0]  number_hold = '0;
    logic [RUN_W-1:0]  unity_run   = '0;
    logic [FRAC_W-1:0] bar_lv      = '0;
    logic [FRAC_W-1:0] peak_lv     = '0;
    logic [CNT_W-1:0]  peak_hold   = '0;

    int log2_tab [TAB_LEN];

    meter_reading_t readings_due [$];

    int  errors          = 0;
    int  results_checked = 0;
    int  active_items    = 0;
    int  tick_count      = 0;
    int  settings_used   = 1;
    int  cycle_count     = 0;
    int  hold_req        = 0;
    int  hold_seen       = 0;
    int  hold_left       = 0;
    bit  calm            = 1'b0;

    swr_peak_hold_meter_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .swr_sample    (swr_sample),
        .power_present (power_present),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .bar_fraction  (bar_fraction),
        .peak_fraction (peak_fraction),
        .shown_swr     (shown_swr),
        .show_value    (show_value),
        .color_class   (color_class)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Fill the log2 mantissa table: square the Q2.30 mantissa repeatedly and
    // collect one result bit per squaring, then round to Q0.16. The last
    // entry is log2(2) exactly.
    initial
    begin : build_log2_table
        longint unsigned y;
        int              r;
        for (int i = 0; i < TAB_LEN - 1; i++)
        begin
            y = (64'd1 << 30) + (longint'(i) << (30 - LOG_BITS));
            r = 0;
            for (int k = 0; k < 17; k++)
            begin
                y = (y * y) >> 30;
                r = r << 1;
                if (y >= (64'd1 << 31))
                begin
                    y = y >> 1;
                    r = r | 1;
                end
            end
            log2_tab[i] = (r + 1) >> 1;
        end
        log2_tab[TAB_LEN - 1] = 65536;
    end

    // log2 of s in Q.16: exponent plus interpolated table value,
    // rounding half up between entries
    function automatic int log2_fix(input int s);
        int e, m, f, idx, rem, a, b;
        e = 0;
        while (e < 13 && (s >> (e + 1)) != 0)
            e++;
        m   = (s << (13 - e)) & 'h3FFF;
        f   = m - 8192;
        idx = f >> SUB_BITS;
        rem = f & ((1 << SUB_BITS) - 1);
        a   = log2_tab[idx];
        b   = log2_tab[idx + 1];
        return (e << 16) + a + (((b - a) * rem + (1 << (SUB_BITS - 1))) >> SUB_BITS);
    endfunction

    // Bar position of an SWR value: 0 at unity, full at the top of the
    // scale, log-scaled by the reciprocal register in between
    function automatic int log_fraction(input int s);
        longint p;
        if (s <= SWR_UNITY)
            return 0;
        if (s >= scale_max)
            return FRAC_FULL;
        p = (longint'(log2_fix(s) - log2_fix(SWR_UNITY)) * inv_log_scale + 32768) >>> 16;
        return (p > FRAC_FULL) ? FRAC_FULL : int'(p);
    endfunction

    // Advance the bench meter by one beat and return the reading it shows
    task automatic predict_meter_reading(input logic tick, input int s, input logic pwr,
                                         output meter_reading_t r);
        bit     take;
        int     v, fr, target, shown;
        longint lvl;
        if (!tick)
        begin
            if (pwr)
            begin
                take = 1'b1;
                if (s <= SWR_UNITY)
                begin
                    // a real value still held wins over a unity reading;
                    // otherwise unity must repeat before it is believed
                    if (last_tx_swr > SWR_REAL_MIN && number_hold != 0)
                        take = 1'b0;
                    else
                    begin
                        if (unity_run < RUN_SAT)
                            unity_run = unity_run + 1'b1;
                        if (unity_run < UNITY_RUN_NEEDED)
                            take = 1'b0;
                    end
                end
                else
                    unity_run = '0;
                if (take)
                begin
                    v = s;
                    if (v > scale_max)
                        v = scale_max;
                    if (v < SWR_UNITY)
                        v = SWR_UNITY;
                    held_swr    = SWR_W'(v);
                    last_tx_swr = SWR_W'(v);
                    number_hold = hold_len;
                    fr = log_fraction(v);
                    if (fr > bar_lv)
                        bar_lv = FRAC_W'(fr);
                    if (fr > peak_lv)
                    begin
                        peak_lv   = FRAC_W'(fr);
                        peak_hold = hold_len;
                    end
                end
            end
        end
        else
        begin
            // drop the bar towards the held value, then let the peak follow
            // the bar once its hold has run out
            target = log_fraction(held_swr);
            if (bar_lv > target + DECAY_EPS)
            begin
                lvl = bar_lv;
                lvl = lvl - (((lvl - target) * bar_decay) >> 16);
                if (lvl < target)
                    lvl = target;
                bar_lv = FRAC_W'(lvl);
            end
            if (peak_lv > bar_lv + DECAY_EPS)
            begin
                if (peak_hold != 0)
                    peak_hold = peak_hold - 1'b1;
                else
                begin
                    lvl = peak_lv;
                    lvl = lvl - (((lvl - bar_lv) * peak_decay) >> 16);
                    if (lvl < bar_lv)
                        lvl = bar_lv;
                    peak_lv = FRAC_W'(lvl);
                end
            end
            if (number_hold != 0 && !pwr && !tune_on)
                number_hold = number_hold - 1'b1;
        end

        shown  = 0;
        r.show = 1'b0;
        if (pwr)
        begin
            shown  = held_swr;
            r.show = 1'b1;
        end
        else if (tune_on || number_hold != 0)
        begin
            if (last_tx_swr > SWR_UNITY)
            begin
                shown  = last_tx_swr;
                r.show = 1'b1;
            end
        end
        r.cls = CLS_BLANK;
        if (r.show)
        begin
            if (shown < good_lim)
                r.cls = CLS_GOOD;
            else if (shown < warn_lim)
                r.cls = CLS_WARNING;
            else
                r.cls = CLS_BAD;
        end
        r.shown = SWR_W'(shown);
        r.bar   = bar_lv;
        r.peak  = peak_lv;
    endtask

    // Offer one beat, hold it until taken, then queue its expected reading.
    // This task lowers valid only for a random gap, so back-to-back beats
    // keep it high.
    task automatic send_beat(input logic tick, input int s, input logic pwr);
        meter_reading_t r;
        int             gap;
        if (!calm && $urandom_range(99) < 12)
        begin
            gap = $urandom_range(14, 2);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        mode          <= tick;
        swr_sample    <= SWR_W'(s);
        power_present <= pwr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_meter_reading(tick, s, pwr, r);
        readings_due.push_back(r);
        if (tick)
            tick_count++;
        // a sample without power leaves the meter untouched
        if (tick || pwr)
            active_items++;
    endtask

    // Pause the sender until every queued reading has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (readings_due.size() != 0)
            @(posedge clk);
    endtask

    // Drain, let the block settle, then write all eight registers
    task automatic change_settings(input int smax, input int inv, input int drate,
                                   input int prate, input int hold, input int good,
                                   input int warn, input int tune);
        int       vals [8];
        cfg_idx_t idx;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        vals[REG_SWR_MAX]         = smax;
        vals[REG_INVERSE_LOG_MAX] = inv;
        vals[REG_DECAY_RATE]      = drate;
        vals[REG_PEAK_DECAY_RATE] = prate;
        vals[REG_HOLD_TICKS]      = hold;
        vals[REG_GOOD_LIMIT]      = good;
        vals[REG_WARNING_LIMIT]   = warn;
        vals[REG_TUNE_MODE]       = tune;
        idx = idx.first();
        repeat (idx.num())
        begin
            cfg_we   <= 1'b1;
            cfg_addr <= idx;
            cfg_data <= CFG_W'(vals[idx]);
            @(posedge clk);
            case (idx)
                REG_SWR_MAX:         scale_max     = SWR_W'(vals[idx]);
                REG_INVERSE_LOG_MAX: inv_log_scale = CFG_W'(vals[idx]);
                REG_DECAY_RATE:      bar_decay     = CFG_W'(vals[idx]);
                REG_PEAK_DECAY_RATE: peak_decay    = CFG_W'(vals[idx]);
                REG_HOLD_TICKS:      hold_len      = CNT_W'(vals[idx]);
                REG_GOOD_LIMIT:      good_lim      = SWR_W'(vals[idx]);
                REG_WARNING_LIMIT:   warn_lim      = SWR_W'(vals[idx]);
                REG_TUNE_MODE:       tune_on       = vals[idx][0];
                default: ;
            endcase
            idx = idx.next();
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Real SWR values, weighted towards the low end, with the scale and
    // class boundaries of the current settings picked often
    function automatic int pick_swr();
        int edges [9];
        int v;
        case ($urandom_range(3))
            0: return $urandom_range(150, 101);
            1: return $urandom_range(400, 150);
            2: return $urandom_range(9999, 400);
            default:
            begin
                edges = '{101, int'(scale_max) - 1, int'(scale_max), int'(scale_max) + 1,
                          int'(good_lim) - 1, int'(good_lim), int'(warn_lim) - 1,
                          int'(warn_lim), 9999};
                v = edges[$urandom_range(8)];
                return (v > 9999) ? 9999 : ((v < 0) ? 0 : v);
            end
        endcase
    endfunction

    // Random traffic shaped like real use: transmit bursts, release with
    // decay ticks, runs of unity readings, and some plain noise
    task automatic drive_meter_traffic(input int n);
        int goal, len;
        goal = active_items + n;
        while (active_items < goal)
        begin
            len = $urandom_range(12, 3);
            case ($urandom_range(9))
                0, 1, 2, 3:
                    repeat (len)
                    begin
                        if ($urandom_range(3) == 0)
                            send_beat(1'b1, $urandom_range(9999), 1'b1);
                        else
                            send_beat(1'b0, pick_swr(), 1'b1);
                    end
                4, 5:
                begin
                    len = $urandom_range(30, 3);
                    repeat (len)
                    begin
                        if ($urandom_range(9) == 0)
                            send_beat(1'b0, $urandom_range(9999), 1'b0);
                        else
                            send_beat(1'b1, $urandom_range(9999), 1'b0);
                    end
                end
                6, 7:
                begin
                    len = $urandom_range(16, 1);
                    repeat (len)
                        send_beat(1'b0, $urandom_range(1) ? SWR_UNITY
                                                          : int'($urandom_range(SWR_UNITY)),
                                  1'b1);
                end
                default:
                    repeat (len / 2)
                        send_beat(1'($urandom_range(1)), $urandom_range(9999),
                                  1'($urandom_range(1)));
            endcase
        end
    endtask

    // Nothing transmitted yet: blank until power, and a stray sample
    // without power is ignored
    task automatic test_blank_readout();
        send_beat(1'b1, 0, 1'b0);
        send_beat(1'b0, 400, 1'b0);
        send_beat(1'b1, 0, 1'b1);
    endtask

    // Smallest real value, clamp at the top, a unity reading rejected while
    // a real value is held, both sides of the good limit and the warning limit
    task automatic test_sample_extremes();
        send_beat(1'b0, 101, 1'b1);
        send_beat(1'b0, 9999, 1'b1);
        send_beat(1'b0, 0, 1'b1);
        send_beat(1'b0, 149, 1'b1);
        send_beat(1'b0, 150, 1'b1);
        send_beat(1'b0, 300, 1'b1);
    endtask

    // Power drops: bar and peak decay, number held
    task automatic test_release_decay();
        send_beat(1'b1, 0, 1'b0);
        send_beat(1'b1, 16383, 1'b0);
        send_beat(1'b0, 700, 1'b0);
    endtask

    // Let a short numeric hold expire, then a run of unity readings is
    // deferred until the tenth one
    task automatic test_unity_run();
        change_settings(SWR_MAX_RST, INVERSE_LOG_MAX_RST, DECAY_RATE_RST,
                        PEAK_DECAY_RATE_RST, 2, GOOD_LIMIT_RST, WARNING_LIMIT_RST, 0);
        send_beat(1'b0, 500, 1'b1);
        send_beat(1'b1, 0, 1'b0);
        send_beat(1'b1, 0, 1'b0);
        for (int i = 0; i < UNITY_RUN_NEEDED; i++)
            send_beat(1'b0, (i % 3 == 0) ? SWR_UNITY : i * 11, 1'b1);
    endtask

    task automatic test_tuned_hold();
        change_settings(SWR_MAX_RST, INVERSE_LOG_MAX_RST, DECAY_RATE_RST,
                        PEAK_DECAY_RATE_RST, 5, GOOD_LIMIT_RST, WARNING_LIMIT_RST, 1);
        drive_meter_traffic(130);
    endtask

    // Widest scale, fastest decay, no hold; run without any idling
    task automatic test_full_scale_extremes();
        change_settings(9999, 9864, 65535, 65535, 0, 100, 100, 1);
        calm = 1'b1;
        drive_meter_traffic(120);
        calm = 1'b0;
    endtask

    // Narrowest scale, no decay, longest hold
    task automatic test_narrow_scale_extremes();
        change_settings(101, 65535, 0, 0, 65535, 9999, 9999, 0);
        drive_meter_traffic(100);
    endtask

    // Scale top below unity, zero reciprocal, warning limit under good limit
    task automatic test_odd_settings();
        change_settings(50, 0, 1, 1, 1, 200, 150, 0);
        drive_meter_traffic(60);
    endtask

    // Hold off the result side while beats keep coming, so the block fills
    // and stalls its input; then pause the sender until all is back and drive more traffic
    task automatic test_backpressure();
        change_settings(500, 28230, 20000, 8000, 3, 130, 200, 0);
        hold_req++;
        drive_meter_traffic(40);
        wait_drained();
        drive_meter_traffic(140);
    endtask

    task automatic compare_field(input string what, input int want, input int got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    // Check every result beat against the oldest pending reading
    always @(posedge clk)
    begin : result_check
        meter_reading_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (readings_due.size() == 0)
            begin
                errors++;
                $display("%0t: result with no reading pending, expected none, actual bar %0d",
                         $time, bar_fraction);
            end
            else
            begin
                want = readings_due.pop_front();
                compare_field("bar_fraction", want.bar, bar_fraction);
                compare_field("peak_fraction", want.peak, peak_fraction);
                compare_field("shown_swr", want.shown, shown_swr);
                compare_field("show_value", want.show, show_value);
                compare_field("color_class", want.cls, color_class);
                results_checked++;
            end
        end
    end

    // Result side: random stalls, none while calm, and a long hold-off
    // whenever one is requested
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else if (hold_seen != hold_req)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_OFF_CYCLES;
            out_ready <= 1'b0;
        end
        else
            out_ready <= calm || ($urandom_range(99) >= 12);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timed out with %0d readings pending", $time, readings_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_blank_readout();
        test_sample_extremes();
        test_release_decay();
        test_unity_run();
        test_tuned_hold();
        test_full_scale_extremes();
        test_narrow_scale_extremes();
        test_odd_settings();
        test_backpressure();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Checked %0d results from %0d meter-changing beats (%0d decay ticks)",
                 results_checked, active_items, tick_count);
        $display("over %0d register settings, with output hold-off and sender pauses",
                 settings_used);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ swr_peak_hold_meter_top.f @@
hdl/swrphm_pkg.sv
hdl/swrphm_ctrl.sv
hdl/swrphm_dp.sv
hdl/swr_peak_hold_meter_top.sv
dv/swr_peak_hold_meter_top_test.sv
